// ===== rtl/core/rsfe_pkg.sv =====
`timescale 1ns / 1ps

package rsfe_pkg;

    // Ring geometry
    localparam int CAPACITY = 1024;
    localparam int SLOT_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int HALF_W   = 64;

    // Request: one 128-bit token key as two halves
    typedef struct packed {
        logic [HALF_W-1:0] key_high;
        logic [HALF_W-1:0] key_low;
    } t_req;

    // Response
    typedef struct packed {
        logic replayed;
        logic inserted;
    } t_rsp;

    // Ring bookkeeping shared between control and sequencer
    typedef struct packed {
        logic [SLOT_W-1:0] oldest;
        logic [SLOT_W-1:0] wr;
        logic [CNT_W-1:0]  live;
    } t_ring_st;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    // Slot increment with wrap at capacity
    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] slot);
        logic [SLOT_W-1:0] res;
        if (slot == SLOT_W'(CAPACITY - 1)) begin
            res = '0;
        end else begin
            res = slot + SLOT_W'(1);
        end
        return res;
    endfunction

endpackage

// ===== rtl/core/rsfe_ram.sv =====
`timescale 1ns / 1ps

// Single-port RAM, registered read
module rsfe_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/rsfe_ring_ctl.sv =====
`timescale 1ns / 1ps

// Write slot, oldest slot and live count of the ring
module rsfe_ring_ctl import rsfe_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_insert,
    output t_ring_st o_ring
);

    t_ring_st r_ring;
    t_ring_st n_ring;

    // Insert: advance write slot; when full, drop the oldest entry
    always_comb begin
        n_ring = r_ring;
        if (i_insert) begin
            n_ring.wr = next_slot(r_ring.wr);
            if (r_ring.live == CNT_W'(CAPACITY)) begin
                n_ring.oldest = next_slot(r_ring.oldest);
            end else begin
                n_ring.live = r_ring.live + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring <= '0;
        end else begin
            r_ring <= n_ring;
        end
    end

    assign o_ring = r_ring;

    // Count never passes capacity
    a_live_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ring.live <= CNT_W'(CAPACITY))
        else $error("live count above capacity");

    // A full ring stays full and moves its oldest slot on insert
    a_full_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_insert && r_ring.live == CNT_W'(CAPACITY))
        |=> (r_ring.live == CNT_W'(CAPACITY)) && (r_ring.oldest != $past(r_ring.oldest)))
        else $error("eviction did not advance oldest slot");

endmodule

// ===== rtl/core/replay_set_fifo_evict_unit.sv =====
`timescale 1ns / 1ps

// Replay detector over a ring of the last CAPACITY distinct 128-bit keys, first-in
// first-out eviction. One request at a time: after a request is taken the unit reads
// the live ring entries one per cycle from the oldest slot through a single RAM port
// and one 128-bit comparator, ending early on a match; a closed store skips the scan
// and inserts nothing. A miss on an open store writes the key in ST_DONE as the
// response is registered. The response sits in an output register, so the next
// request is taken while it waits.
// No clearing pass after reset: only written slots are ever read.
module replay_set_fifo_evict_unit import rsfe_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    // configuration
    input  logic i_cfg_we,
    input  logic i_cfg_wdata,
    // request channel
    input  logic i_req_valid,
    output logic o_req_ready,
    input  t_req i_req,
    // response channel
    output logic o_rsp_valid,
    input  logic i_rsp_ready,
    output t_rsp o_rsp
);

    t_state r_state, n_state;
    logic   r_closed;
    t_req   r_key, n_key;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic [CNT_W-1:0]  r_left, n_left;
    logic   r_pend, n_pend;
    logic   r_hit, n_hit;
    logic   r_skip, n_skip;
    logic   r_out_valid, n_out_valid;
    t_rsp   r_out, n_out;

    logic              ram_we, ram_re;
    logic [SLOT_W-1:0] ram_addr;
    logic [HALF_W-1:0] rd_high, rd_low;
    logic              key_eq, out_free, insert;
    t_ring_st          ring;

    // Store-closed register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_closed <= 1'b0;
        end else if (i_cfg_we) begin
            r_closed <= i_cfg_wdata;
        end
    end

    // Key halves of the ring
    rsfe_ram #(.WIDTH(HALF_W), .DEPTH(CAPACITY)) u_ram_high (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (ram_re),
        .i_addr  (ram_addr),
        .i_wdata (r_key.key_high),
        .o_rdata (rd_high)
    );

    rsfe_ram #(.WIDTH(HALF_W), .DEPTH(CAPACITY)) u_ram_low (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (ram_re),
        .i_addr  (ram_addr),
        .i_wdata (r_key.key_low),
        .o_rdata (rd_low)
    );

    rsfe_ring_ctl u_ring_ctl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_insert (insert),
        .o_ring   (ring)
    );

    // Shared comparator on the entry read last cycle
    assign key_eq   = (rd_high == r_key.key_high) && (rd_low == r_key.key_low);
    assign out_free = !r_out_valid || i_rsp_ready;

    // Sequencer: next state and datapath control
    always_comb begin
        n_state     = r_state;
        n_key       = r_key;
        n_slot      = r_slot;
        n_left      = r_left;
        n_pend      = 1'b0;
        n_hit       = r_hit;
        n_skip      = r_skip;
        n_out_valid = r_out_valid && !i_rsp_ready;
        n_out       = r_out;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_addr    = r_slot;
        insert      = 1'b0;
        o_req_ready = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    n_key   = i_req;
                    n_hit   = 1'b0;
                    n_skip  = r_closed;
                    n_slot  = ring.oldest;
                    n_left  = ring.live;
                    n_state = r_closed ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_pend && key_eq) begin
                    // match on a live entry
                    n_hit   = 1'b1;
                    n_state = ST_DONE;
                end else begin
                    ram_re = (r_left != '0);
                    n_pend = ram_re;
                    if (ram_re) begin
                        n_slot = next_slot(r_slot);
                        n_left = r_left - CNT_W'(1);
                    end else if (!r_pend) begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    insert           = !r_hit && !r_skip;
                    ram_we           = insert;
                    ram_addr         = ring.wr;
                    n_out_valid      = 1'b1;
                    n_out.replayed   = r_hit;
                    n_out.inserted   = insert;
                    n_state          = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pend      <= 1'b0;
            r_hit       <= 1'b0;
            r_skip      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pend      <= n_pend;
            r_hit       <= n_hit;
            r_skip      <= n_skip;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_key  <= n_key;
        r_slot <= n_slot;
        r_left <= n_left;
        r_out  <= n_out;
    end

    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

    // RAM is never read and written in the same cycle
    a_port_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_we && ram_re))
        else $error("ring read and write collide");

    // A write happens only when the response is committed
    a_write_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |=> r_out_valid && r_out.inserted && (r_state == ST_IDLE))
        else $error("ring write without insert response");

    // A response never reports both replay and insert
    a_rsp_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.replayed && r_out.inserted))
        else $error("response flags both set");

    // Scan never reads past the live entries
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_left <= ring.live))
        else $error("scan count above live entries");

endmodule
